/* rtl/bgf_pkg.sv */
// ----------------------------------------------------------------------------
// bgf_pkg
// Shared types and constants for the background fetcher and pixel queue.
// ----------------------------------------------------------------------------
package bgf_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int VRAM_BYTES  = 8192;
  localparam int VRAM_AW     = $clog2(VRAM_BYTES);

  localparam logic [VRAM_AW-1:0] MAP_LOW   = VRAM_AW'(16'h1800);
  localparam logic [VRAM_AW-1:0] MAP_HIGH  = VRAM_AW'(16'h1C00);
  localparam logic [VRAM_AW-1:0] AREA_HIGH = VRAM_AW'(16'h0800);

  localparam logic [8:0] WIN_X_SPAN = 9'd158;
  localparam logic [8:0] WIN_Y_SPAN = 9'd160;

  typedef enum logic [2:0] {
    REG_LCDC  = 3'd0,
    REG_SCX   = 3'd1,
    REG_SCY   = 3'd2,
    REG_WX    = 3'd3,
    REG_WY    = 3'd4,
    REG_BGP   = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_LINE  = 2'd2,
    ACT_NONE  = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    PH_TILE  = 3'd0,
    PH_LOW   = 3'd1,
    PH_HIGH  = 3'd2,
    PH_SLEEP = 3'd3,
    PH_PUSH  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_TILE = 2'd1,
    RD_LOW  = 2'd2,
    RD_HIGH = 2'd3
  } rd_kind_t;

  typedef struct packed {
    act_t               kind;
    logic [VRAM_AW-1:0] vram_offset;
    logic [7:0]         vram_byte;
    logic [7:0]         line_number;
    logic [7:0]         window_line_count;
  } item_t;

  typedef struct packed {
    logic [7:0] lcd_control;
    logic [7:0] scroll_x;
    logic [7:0] scroll_y;
    logic [7:0] window_x;
    logic [7:0] window_y;
    logic [7:0] bg_palette;
  } cfg_t;

endpackage

/* rtl/bgf_front.sv */
// ----------------------------------------------------------------------------
// bgf_front
// Accepts input beats, classifies the action code and holds them in a
// two-entry queue for the execute side.
// ----------------------------------------------------------------------------
module bgf_front import bgf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic [VRAM_AW-1:0] vram_offset,
  input  logic [7:0]         vram_byte,
  input  logic [7:0]         line_number,
  input  logic [7:0]         window_line_count,
  output logic               itm_valid,
  output item_t              itm,
  input  logic               itm_take
);

  item_t      ent [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  item_t      cls;

  always_comb begin
    cls.kind              = act_t'(action);
    cls.vram_offset       = vram_offset;
    cls.vram_byte         = vram_byte;
    cls.line_number       = line_number;
    cls.window_line_count = window_line_count;
  end

  assign in_stall  = (count == 2'd2);
  assign push      = in_valid && !in_stall;
  assign itm_valid = (count != 2'd0);
  assign itm       = ent[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (itm_take) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, itm_take};
    end
  end

endmodule

/* rtl/bgf_vram.sv */
// ----------------------------------------------------------------------------
// bgf_vram
// Video RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bgf_vram import bgf_pkg::*; (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [VRAM_AW-1:0] wr_addr,
  input  logic [7:0]         wr_data,
  input  logic               rd_en,
  input  logic [VRAM_AW-1:0] rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [VRAM_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/bgf_back.sv */
// ----------------------------------------------------------------------------
// bgf_back
// Executes one item a cycle while the output is not stalled: fetcher phases,
// shade queue push and pop, video RAM access and the output register.
// ----------------------------------------------------------------------------
module bgf_back import bgf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       itm_valid,
  input  item_t      itm,
  output logic       itm_take,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       pixel_valid,
  output logic [7:0] pixel_x,
  output logic [7:0] pixel_y,
  output logic [1:0] pixel_shade,
  output logic [7:0] pushed_count
);

  phase_t              phase, phase_next;
  logic                toggle, toggle_next;
  logic [7:0]          fetch_column, fetch_column_next;
  logic [7:0]          tile_number, tile_number_next;
  logic [7:0]          plane_low, plane_low_next;
  logic [7:0]          plane_high, plane_high_next;
  logic [1:0]          queue [QUEUE_DEPTH];
  logic [1:0]          queue_next [QUEUE_DEPTH];
  logic [FILL_W-1:0]   fill, fill_next;
  logic [7:0]          discard_count, discard_next;
  logic [7:0]          emit_column, emit_next;
  rd_kind_t            pend, pend_next;

  logic                wr_en;
  logic                rd_en;
  logic [VRAM_AW-1:0]  rd_addr;
  logic [7:0]          rd_data;

  logic                emit;
  logic [1:0]          emit_shade;

  logic [8:0]          col7;
  logic [8:0]          line9;
  logic                in_win;
  logic [7:0]          win_off;
  logic [8:0]          bg_col_sum;
  logic [7:0]          row_sum;
  logic [VRAM_AW-1:0]  map_base;
  logic [VRAM_AW-1:0]  area_base;
  logic [3:0]          push_min;
  logic                push_ok;
  logic [FILL_W:0]     diff;
  logic [1:0]          cid;
  logic [1:0]          q_p [QUEUE_DEPTH];
  logic [FILL_W-1:0]   fill_p;

  assign itm_take = itm_valid && (!out_valid || !out_stall);
  assign wr_en    = itm_take && (itm.kind == ACT_WRITE);

  bgf_vram u_vram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (itm.vram_offset),
    .wr_data (itm.vram_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // address helpers
  always_comb begin
    col7       = {1'b0, fetch_column} + 9'd7;
    line9      = {1'b0, itm.line_number};
    in_win     = cfg.lcd_control[5] &&
                 (col7 >= {1'b0, cfg.window_x}) &&
                 (col7 < ({1'b0, cfg.window_x} + WIN_X_SPAN)) &&
                 (line9 >= {1'b0, cfg.window_y}) &&
                 (line9 < ({1'b0, cfg.window_y} + WIN_Y_SPAN));
    win_off    = 8'(col7 - {1'b0, cfg.window_x});
    bg_col_sum = {1'b0, cfg.scroll_x} + {1'b0, fetch_column};
    row_sum    = itm.line_number + cfg.scroll_y;
    area_base  = cfg.lcd_control[4] ? '0 : AREA_HIGH;
    push_min   = 4'd8 - {1'b0, cfg.scroll_x[2:0]};
    push_ok    = (fill <= FILL_W'(8));
    if (in_win) begin
      map_base = cfg.lcd_control[6] ? MAP_HIGH : MAP_LOW;
    end else begin
      map_base = cfg.lcd_control[3] ? MAP_HIGH : MAP_LOW;
    end
  end

  always_comb begin
    phase_next        = phase;
    toggle_next       = toggle;
    fetch_column_next = fetch_column;
    tile_number_next  = tile_number;
    plane_low_next    = plane_low;
    plane_high_next   = plane_high;
    fill_next         = fill;
    discard_next      = discard_count;
    emit_next         = emit_column;
    pend_next         = RD_NONE;
    rd_en             = 1'b0;
    rd_addr           = '0;
    emit              = 1'b0;
    emit_shade        = 2'd0;
    fill_p            = fill;
    diff              = '0;
    cid               = 2'd0;
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      q_p[k]        = queue[k];
      queue_next[k] = queue[k];
    end

    // read data from the previous cycle lands first
    unique case (pend)
      RD_TILE: tile_number_next = cfg.lcd_control[4] ? rd_data : (rd_data ^ 8'h80);
      RD_LOW:  plane_low_next   = rd_data;
      RD_HIGH: plane_high_next  = rd_data;
      RD_NONE: ;
      default: ;
    endcase

    if (itm_take) begin
      unique case (itm.kind)
        ACT_LINE: begin
          phase_next        = PH_TILE;
          fetch_column_next = 8'd0;
          plane_low_next    = 8'd0;
          plane_high_next   = 8'd0;
          fill_next         = '0;
          discard_next      = 8'd0;
          emit_next         = 8'd0;
        end
        ACT_TICK: begin
          toggle_next = ~toggle;
          if (toggle) begin
            unique case (phase)
              PH_LOW: begin
                rd_en      = 1'b1;
                rd_addr    = area_base + {1'b0, tile_number, row_sum[2:0], 1'b0};
                pend_next  = RD_LOW;
                phase_next = PH_HIGH;
              end
              PH_HIGH: begin
                rd_en      = 1'b1;
                rd_addr    = area_base + {1'b0, tile_number, row_sum[2:0], 1'b1};
                pend_next  = RD_HIGH;
                phase_next = PH_SLEEP;
              end
              PH_SLEEP: phase_next = PH_PUSH;
              PH_PUSH: begin
                if (push_ok) begin
                  phase_next = PH_TILE;
                  if ({1'b0, fetch_column} >= {5'd0, push_min}) begin
                    for (int k = 0; k < QUEUE_DEPTH; k++) begin
                      diff = (FILL_W+1)'(k) - {1'b0, fill};
                      cid  = cfg.lcd_control[0] ?
                             {plane_high[~diff[2:0]], plane_low[~diff[2:0]]} : 2'd0;
                      if (((FILL_W+1)'(k) >= {1'b0, fill}) &&
                          (diff < (FILL_W+1)'(8))) begin
                        q_p[k] = cfg.bg_palette[{cid, 1'b0} +: 2];
                      end
                    end
                    fill_p = (fill + FILL_W'(8) > FILL_W'(QUEUE_DEPTH)) ?
                             FILL_W'(QUEUE_DEPTH) : fill + FILL_W'(8);
                  end
                end
              end
              default: begin
                // tile id phase
                if (cfg.lcd_control[0]) begin
                  rd_en     = 1'b1;
                  pend_next = RD_TILE;
                  if (in_win) begin
                    rd_addr = map_base + VRAM_AW'(win_off[7:3]) +
                              VRAM_AW'({itm.window_line_count[7:3], 5'd0});
                  end else begin
                    rd_addr = map_base + VRAM_AW'({row_sum[7:3], bg_col_sum[7:3]});
                  end
                end
                fetch_column_next = fetch_column + 8'd8;
                phase_next        = PH_LOW;
              end
            endcase
          end
          fill_next = fill_p;
          for (int k = 0; k < QUEUE_DEPTH; k++) begin
            queue_next[k] = q_p[k];
          end
          if (fill_p > FILL_W'(8)) begin
            for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
              queue_next[k] = q_p[k+1];
            end
            fill_next    = fill_p - FILL_W'(1);
            discard_next = discard_count + 8'd1;
            if (discard_count >= {5'd0, cfg.scroll_x[2:0]}) begin
              emit       = 1'b1;
              emit_shade = q_p[0];
              emit_next  = emit_column + 8'd1;
            end
          end
        end
        ACT_WRITE: ;
        ACT_NONE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      queue[k] <= queue_next[k];
    end
    tile_number <= tile_number_next;
    plane_low   <= plane_low_next;
    plane_high  <= plane_high_next;
    if (itm_take) begin
      pixel_valid  <= emit;
      pixel_x      <= emit ? emit_column : 8'd0;
      pixel_y      <= emit ? itm.line_number : 8'd0;
      pixel_shade  <= emit_shade;
      pushed_count <= emit_next;
    end
    if (rst) begin
      tile_number <= 8'd0;
      plane_low   <= 8'd0;
      plane_high  <= 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TILE;
      toggle        <= 1'b0;
      fetch_column  <= 8'd0;
      fill          <= '0;
      discard_count <= 8'd0;
      emit_column   <= 8'd0;
      pend          <= RD_NONE;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      toggle        <= toggle_next;
      fetch_column  <= fetch_column_next;
      fill          <= fill_next;
      discard_count <= discard_next;
      emit_column   <= emit_next;
      pend          <= pend_next;
      if (itm_take) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/background_tile_fetcher_pixel_fifo.sv */
// ----------------------------------------------------------------------------
// background_tile_fetcher_pixel_fifo
// Background/window tile fetcher with video RAM and a queue of shades.
//
//   channel | signals                                     | beat on
//   in      | in_valid, in_stall, action .. window_line   | valid & !stall
//   out     | out_valid, out_stall, pixel_*, pushed_count | valid & !stall
//   cfg     | cfg_write, cfg_index, cfg_data              | cfg_write
//
// one item per cycle sustained while out_stall is low; a beat waits in the
// input queue, and its result is registered when taken. a fetch read returns
// from the video RAM read port the cycle after it issues and updates the
// fetcher then. reset clears control state; video RAM is not cleared.
// out_stall holds the output register; the input queue keeps taking beats
// until both of its entries are full, and stays stalled for the cycle in
// which out_stall lifts.
// ----------------------------------------------------------------------------
module background_tile_fetcher_pixel_fifo import bgf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic [VRAM_AW-1:0] vram_offset,
  input  logic [7:0]         vram_byte,
  input  logic [7:0]         line_number,
  input  logic [7:0]         window_line_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               pixel_valid,
  output logic [7:0]         pixel_x,
  output logic [7:0]         pixel_y,
  output logic [1:0]         pixel_shade,
  output logic [7:0]         pushed_count
);

  cfg_t  cfg;
  logic  itm_valid;
  item_t itm;
  logic  itm_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LCDC: cfg.lcd_control <= cfg_data;
        REG_SCX:  cfg.scroll_x    <= cfg_data;
        REG_SCY:  cfg.scroll_y    <= cfg_data;
        REG_WX:   cfg.window_x    <= cfg_data;
        REG_WY:   cfg.window_y    <= cfg_data;
        REG_BGP:  cfg.bg_palette  <= cfg_data;
        default: ;
      endcase
    end
  end

  bgf_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .action            (action),
    .vram_offset       (vram_offset),
    .vram_byte         (vram_byte),
    .line_number       (line_number),
    .window_line_count (window_line_count),
    .itm_valid         (itm_valid),
    .itm               (itm),
    .itm_take          (itm_take)
  );

  bgf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .itm_valid    (itm_valid),
    .itm          (itm),
    .itm_take     (itm_take),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_valid  (pixel_valid),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_shade  (pixel_shade),
    .pushed_count (pushed_count)
  );

endmodule

/* verif/bgf_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bgf_checker
// Watches the item, config and pixel channels of the background fetcher,
// runs its own prediction of the fetcher and shade queue, and compares
// every pixel beat field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module bgf_checker import bgf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         action,
  input  logic [VRAM_AW-1:0] vram_offset,
  input  logic [7:0]         vram_byte,
  input  logic [7:0]         line_number,
  input  logic [7:0]         window_line_count,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               pixel_valid,
  input  logic [7:0]         pixel_x,
  input  logic [7:0]         pixel_y,
  input  logic [1:0]         pixel_shade,
  input  logic [7:0]         pushed_count,
  output int                 errors,
  output int                 pending,
  output int                 pixels_seen
);

  typedef struct {
    bit       shown;
    bit [7:0] col;
    bit [7:0] row;
    bit [1:0] shade;
    bit [7:0] count;
  } pixel_t;

  pixel_t     expected_pixels[$];
  cfg_t       regs;
  bit [7:0]   vram [VRAM_BYTES];
  phase_t     phase;
  bit         half_tick;
  bit [7:0]   fetch_col;
  bit [7:0]   tile_id;
  bit [7:0]   row_low;
  bit [7:0]   row_high;
  bit [1:0]   shades[$];
  bit [7:0]   drop_count;
  bit [7:0]   emit_col;

  assign pending = expected_pixels.size();

  function automatic void clear_line();
    phase      = PH_TILE;
    fetch_col  = 0;
    row_low    = 0;
    row_high   = 0;
    shades     = {};
    drop_count = 0;
    emit_col   = 0;
  endfunction

  function automatic bit [7:0] plane_byte(int line, int plane);
    int area;
    area = regs.lcd_control[4] ? 0 : int'(AREA_HIGH);
    return vram[(area + tile_id * 16 + ((line + regs.scroll_y) & 7) * 2 + plane) % VRAM_BYTES];
  endfunction

  function automatic void fetch_tile_id(int line, int win_line);
    int col7, wx, wy, addr, base;
    bit in_win;
    col7 = fetch_col + 7;
    wx = regs.window_x;
    wy = regs.window_y;
    if (regs.lcd_control[0]) begin
      in_win = regs.lcd_control[5] && col7 >= wx && col7 < wx + 158 &&
               line >= wy && line < wy + 160;
      if (in_win) begin
        base = regs.lcd_control[6] ? int'(MAP_HIGH) : int'(MAP_LOW);
        addr = base + (col7 - wx) / 8 + (win_line / 8) * 32;
      end else begin
        base = regs.lcd_control[3] ? int'(MAP_HIGH) : int'(MAP_LOW);
        addr = base + (((regs.scroll_x + fetch_col) / 8) & 31) +
               (((line + regs.scroll_y) & 255) / 8) * 32;
      end
      tile_id = vram[addr % VRAM_BYTES];
      if (!regs.lcd_control[4]) tile_id = tile_id + 8'd128;
    end
    fetch_col = fetch_col + 8'd8;
  endfunction

  // returns 0 while the queue is too full to take eight more
  function automatic bit push_row();
    int x;
    bit [1:0] id;
    if (shades.size() > 8) return 0;
    x = int'(fetch_col) - (8 - int'(regs.scroll_x[2:0]));
    if (x < 0) return 1;
    for (int i = 7; i >= 0; i--) begin
      id = regs.lcd_control[0] ? {row_high[i], row_low[i]} : 2'd0;
      if (shades.size() < QUEUE_DEPTH) shades.push_back(regs.bg_palette[id*2 +: 2]);
    end
    return 1;
  endfunction

  function automatic void fetcher_advance(int line, int win_line);
    case (phase)
      PH_LOW: begin
        row_low = plane_byte(line, 0);
        phase = PH_HIGH;
      end
      PH_HIGH: begin
        row_high = plane_byte(line, 1);
        phase = PH_SLEEP;
      end
      PH_SLEEP: phase = PH_PUSH;
      PH_PUSH: if (push_row()) phase = PH_TILE;
      default: begin
        fetch_tile_id(line, win_line);
        phase = PH_LOW;
      end
    endcase
  endfunction

  function automatic pixel_t predict_pixel(act_t kind, bit [VRAM_AW-1:0] offs,
                                           bit [7:0] data, bit [7:0] line,
                                           bit [7:0] win_line);
    pixel_t r;
    r = '{default: 0};
    case (kind)
      ACT_WRITE: vram[offs] = data;
      ACT_LINE:  clear_line();
      ACT_TICK: begin
        if (half_tick) fetcher_advance(line, win_line);
        half_tick = !half_tick;
        if (shades.size() > 8) begin
          if (drop_count >= regs.scroll_x[2:0]) begin
            r.shown = 1;
            r.col   = emit_col;
            r.row   = line;
            r.shade = shades[0];
            emit_col = emit_col + 8'd1;
          end
          void'(shades.pop_front());
          drop_count = drop_count + 8'd1;
        end
      end
      default: ;
    endcase
    r.count = emit_col;
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    pixels_seen = 0;
  end

  always @(posedge clk) begin
    pixel_t e;
    if (rst) begin
      regs = '0;
      half_tick = 0;
      tile_id = 0;
      clear_line();
      expected_pixels = {};
    end else begin
      if (cfg_write) begin
        case (reg_idx_t'(cfg_index))
          REG_LCDC: regs.lcd_control = cfg_data;
          REG_SCX:  regs.scroll_x    = cfg_data;
          REG_SCY:  regs.scroll_y    = cfg_data;
          REG_WX:   regs.window_x    = cfg_data;
          REG_WY:   regs.window_y    = cfg_data;
          REG_BGP:  regs.bg_palette  = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          report("unexpected beat, pushed_count", pushed_count, -1);
        end else begin
          e = expected_pixels.pop_front();
          if (pixel_valid !== e.shown)  report("pixel_valid", pixel_valid, e.shown);
          if (pixel_x !== e.col)        report("pixel_x", pixel_x, e.col);
          if (pixel_y !== e.row)        report("pixel_y", pixel_y, e.row);
          if (pixel_shade !== e.shade)  report("pixel_shade", pixel_shade, e.shade);
          if (pushed_count !== e.count) report("pushed_count", pushed_count, e.count);
          if (e.shown) pixels_seen++;
        end
      end
      if (in_valid && !in_stall)
        expected_pixels.push_back(predict_pixel(act_t'(action), vram_offset, vram_byte,
                                                line_number, window_line_count));
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the background fetcher: fills the tile rows and map entries
// that fetches can reach, runs a directed set of items, then random scan
// lines of ticks under several register settings and idle patterns.
// Checking is done by bgf_checker.
// ----------------------------------------------------------------------------
module testbench;
  import bgf_pkg::*;

  localparam int  LIMIT       = 600000;
  localparam logic [2:0] REG_SPARE = 3'd6;  // not a register, writes are dropped

  // map entries hold only these tile ids, so every plane read lands in three
  // small regions of tile data whatever the data area setting
  localparam logic [7:0] TILE_BASE   = 8'h80;
  localparam int         TILE_REGION = 32;
  localparam int         TILE_STRIDE = 'h800;
  // map columns a line can reach before it ends
  localparam int         MAP_SPAN    = 9;

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_write = 0;
  logic [2:0]         cfg_index = '0;
  logic [7:0]         cfg_data = '0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [1:0]         action = ACT_TICK;
  logic [VRAM_AW-1:0] vram_offset = '0;
  logic [7:0]         vram_byte = '0;
  logic [7:0]         line_number = '0;
  logic [7:0]         window_line_count = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic               pixel_valid;
  logic [7:0]         pixel_x, pixel_y, pushed_count;
  logic [1:0]         pixel_shade;
  int                 errors, pending, pixels_seen;
  int                 tx_idle_pct = 0, rx_idle_pct = 0;
  int                 items_sent = 0, cycles = 0;

  always #4 clk = ~clk;

  background_tile_fetcher_pixel_fifo u_dut (.*);

  bgf_checker u_checker (.*);

  always @(negedge clk) out_stall <= !rst && ($urandom_range(99) < rx_idle_pct);

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [VRAM_AW-1:0] tile_addr();
    return VRAM_AW'($urandom_range(2) * TILE_STRIDE + $urandom_range(TILE_REGION - 1));
  endfunction

  // caller is at a falling edge; returns at the falling edge after the beat
  task automatic send_item(act_t kind, logic [VRAM_AW-1:0] offs, logic [7:0] data,
                           logic [7:0] line, logic [7:0] win_line);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid          <= 1;
    action            <= kind;
    vram_offset       <= offs;
    vram_byte         <= data;
    line_number       <= line;
    window_line_count <= win_line;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_regs(cfg_t c);
    logic [7:0] vals[6];
    vals = '{c.lcd_control, c.scroll_x, c.scroll_y, c.window_x, c.window_y, c.bg_palette};
    for (int i = 0; i < 6; i++) begin
      cfg_write <= 1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      @(negedge clk);
    end
    cfg_write <= 0;
    @(negedge clk);
  endtask

  // tile rows for both tile ids under either data area, and stale ids
  task automatic fill_tiles();
    for (int t = 0; t < 3; t++)
      for (int b = 0; b < TILE_REGION; b++)
        send_item(ACT_WRITE, VRAM_AW'(t * TILE_STRIDE + b), 8'($urandom), 8'd0, 8'd0);
  endtask

  // map entries a line can fetch under register setting c
  task automatic prep_maps(cfg_t c, logic [7:0] line, logic [7:0] win_line);
    int bg_map, win_map, col7;
    bg_map  = c.lcd_control[3] ? int'(MAP_HIGH) : int'(MAP_LOW);
    win_map = c.lcd_control[6] ? int'(MAP_HIGH) : int'(MAP_LOW);
    if (c.lcd_control[0]) begin
      for (int k = 0; k < MAP_SPAN; k++) begin
        send_item(ACT_WRITE,
                  VRAM_AW'(bg_map + (((c.scroll_x + 8 * k) / 8) & 31) +
                           (((line + c.scroll_y) & 255) / 8) * 32),
                  TILE_BASE | 8'($urandom_range(1)), line, win_line);
        col7 = 8 * k + 7;
        if (c.lcd_control[5] && col7 >= c.window_x && col7 < c.window_x + 158)
          send_item(ACT_WRITE,
                    VRAM_AW'(win_map + (col7 - c.window_x) / 8 + (win_line / 8) * 32),
                    TILE_BASE | 8'($urandom_range(1)), line, win_line);
      end
    end
  endtask

  task automatic random_line(cfg_t c, int ticks);
    logic [7:0] line, win_line;
    line = 8'($urandom_range(153));
    win_line = 8'($urandom_range(255));
    prep_maps(c, line, win_line);
    send_item(ACT_LINE, 13'($urandom), 8'($urandom), line, win_line);
    for (int i = 0; i < ticks; i++) begin
      case ($urandom_range(19))
        0: send_item(ACT_WRITE, tile_addr(), 8'($urandom), line, win_line);
        1: send_item(ACT_NONE, 13'($urandom), 8'($urandom), line, win_line);
        default: send_item(ACT_TICK, 13'($urandom), 8'($urandom), line, win_line);
      endcase
    end
  endtask

  initial begin
    cfg_t c;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // every tile row that a fetch can reach gets written first
    fill_tiles();

    // directed part
    drain();
    c = '{lcd_control: 8'h91, scroll_x: 8'd3, scroll_y: 8'd0,
          window_x: 8'd0, window_y: 8'd0, bg_palette: 8'hE4};
    write_regs(c);
    cfg_write <= 1;
    cfg_index <= REG_SPARE;
    cfg_data  <= 8'hFF;
    @(negedge clk);
    cfg_write <= 0;
    @(negedge clk);
    prep_maps(c, 8'd0, 8'd0);
    prep_maps(c, 8'd153, 8'd255);
    send_item(ACT_WRITE, 13'd0, 8'hFF, 8'd0, 8'd0);
    send_item(ACT_WRITE, 13'd8191, 8'h00, 8'd153, 8'd255);
    send_item(ACT_NONE, 13'h1FFF, 8'hFF, 8'd153, 8'd255);
    send_item(ACT_LINE, 13'd0, 8'd0, 8'd0, 8'd0);
    for (int i = 0; i < 20; i++)
      send_item(ACT_TICK, 13'd0, 8'd0, (i < 10) ? 8'd0 : 8'd153, (i < 10) ? 8'd0 : 8'd255);

    // random part: idle patterns go receiver-heavy, sender-heavy, then none
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: c = '{default: 8'hFF};
        1: c = '{default: 8'h00};
        default: begin
          c = cfg_t'(48'({$urandom, $urandom}));
          c.lcd_control = c.lcd_control | 8'h21;
        end
      endcase
      write_regs(c);
      tx_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 64 : 0;
      rx_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 31 : 0;
      random_line(c, $urandom_range(20, 40));
      if (ph == 1) drain();
      random_line(c, $urandom_range(30, 50));
    end

    drain();
    repeat (10) @(negedge clk);
    $display("sent %0d items (tile and map fill, directed and random lines)", items_sent);
    $display("checked %0d emitted pixels over 5 register settings", pixels_seen);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/bgf_pkg.sv
rtl/bgf_front.sv
rtl/bgf_vram.sv
rtl/bgf_back.sv
rtl/background_tile_fetcher_pixel_fifo.sv
verif/bgf_checker.sv
verif/testbench.sv
